// File: rtl/drgbc_ma_pkg.sv
// Package with shared types and constants of the dual RGBC moving average.
`timescale 1ns / 1ps

package drgbc_ma_pkg;

   // Width of every channel field on the ports.
   localparam int IN_BITS = 16;

   // Number of color channels in one reading: red, green, blue, clear.
   localparam int NUM_LANES = 4;

   // Lane order inside a stored reading, from the low bits up.
   localparam int LANE_RED   = 0;
   localparam int LANE_GREEN = 1;
   localparam int LANE_BLUE  = 2;
   localparam int LANE_CLEAR = 3;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_SCAN,
      ST_DRAIN,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic capture;
      logic write;
      logic read;
      logic divide;
      logic load_out;
   } cmd_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

// File: rtl/drgbc_ma_if.sv
// Valid/ready channel interfaces for the request and response items.
`timescale 1ns / 1ps

interface drgbc_ma_req_if import drgbc_ma_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               side;
   logic               sample_ok;
   logic [IN_BITS-1:0] red_in;
   logic [IN_BITS-1:0] green_in;
   logic [IN_BITS-1:0] blue_in;
   logic [IN_BITS-1:0] clear_in;

   modport source (output valid, side, sample_ok, red_in, green_in, blue_in, clear_in,
                   input ready);
   modport sink (input valid, side, sample_ok, red_in, green_in, blue_in, clear_in,
                 output ready);
endinterface

interface drgbc_ma_rsp_if import drgbc_ma_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [IN_BITS-1:0] red_avg;
   logic [IN_BITS-1:0] green_avg;
   logic [IN_BITS-1:0] blue_avg;
   logic [IN_BITS-1:0] clear_avg;
   logic               avg_valid;

   modport source (output valid, red_avg, green_avg, blue_avg, clear_avg, avg_valid,
                   input ready);
   modport sink (input valid, red_avg, green_avg, blue_avg, clear_avg, avg_valid,
                 output ready);
endinterface

// File: rtl/drgbc_ma_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module drgbc_ma_ram #(
   parameter int  WIDTH  = 64,
   parameter int  DEPTH  = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/drgbc_ma_ctrl.sv
// Sequencer that steps one item through store, ring scan, division and output.
`timescale 1ns / 1ps

module drgbc_ma_ctrl import drgbc_ma_pkg::*; #(
   parameter int  WINDOW_DEPTH = 4,
   parameter int  SUM_W        = 18,
   localparam int IDX_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1,
   localparam int STEP_W       = $clog2(SUM_W)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  status_type       status,
   output cmd_type          cmd,
   output logic [IDX_W-1:0] scan_idx
);

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  scan_idx_ff, scan_idx_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              scan_last;
   logic              step_last;

   assign scan_last = (scan_idx_ff == IDX_W'(WINDOW_DEPTH - 1));
   assign step_last = (step_ff == STEP_W'(SUM_W - 1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (step_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs per state.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
         end
         ST_SCAN: begin
            cmd.read = 1'b1;
         end
         ST_DRAIN: begin
            cmd = '0;
         end
         ST_DIVIDE: begin
            cmd.divide = 1'b1;
         end
         ST_DONE: begin
            cmd.load_out = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // Scan index and divide step counters.
   always_comb begin
      scan_idx_in = scan_idx_ff;
      step_in     = step_ff;
      if (state_ff == ST_WRITE) begin
         scan_idx_in = '0;
      end else if (state_ff == ST_SCAN && !scan_last) begin
         scan_idx_in = scan_idx_ff + IDX_W'(1);
      end
      if (state_ff == ST_DRAIN) begin
         step_in = '0;
      end else if (state_ff == ST_DIVIDE && !step_last) begin
         step_in = step_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         scan_idx_ff <= '0;
         step_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         scan_idx_ff <= scan_idx_in;
         step_ff     <= step_in;
      end
   end

   assign scan_idx = scan_idx_ff;

`ifndef NO_ASSERTIONS
   // The scan never addresses beyond the ring.
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_idx_ff <= IDX_W'(WINDOW_DEPTH - 1)))
      else $error("scan index beyond ring depth");

   // The division always starts at step zero after the drain state.
   a_divide_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |=> (state_ff == ST_DIVIDE && step_ff == '0))
      else $error("division did not start at step zero");
`endif

endmodule

// File: rtl/drgbc_ma_dp.sv
// Datapath: item capture, ring storage, marks, accumulation, divider and output register.
`timescale 1ns / 1ps

module drgbc_ma_dp import drgbc_ma_pkg::*; #(
   parameter int  WINDOW_DEPTH = 4,
   parameter int  CHANNEL_BITS = 16,
   localparam int IDX_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1,
   localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1),
   localparam int SUM_W        = CHANNEL_BITS + $clog2(WINDOW_DEPTH)
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic [IDX_W-1:0]   scan_idx,
   input  logic               req_side,
   input  logic               req_sample_ok,
   input  logic [IN_BITS-1:0] req_red_in,
   input  logic [IN_BITS-1:0] req_green_in,
   input  logic [IN_BITS-1:0] req_blue_in,
   input  logic [IN_BITS-1:0] req_clear_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [IN_BITS-1:0] rsp_red_avg,
   output logic [IN_BITS-1:0] rsp_green_avg,
   output logic [IN_BITS-1:0] rsp_blue_avg,
   output logic [IN_BITS-1:0] rsp_clear_avg,
   output logic               rsp_avg_valid
);

   localparam int ROW_W  = NUM_LANES * CHANNEL_BITS;
   localparam int RAM_D  = 2 * (1 << IDX_W);
   localparam int ADDR_W = IDX_W + 1;

   // Captured item.
   logic             side_ff;
   logic             ok_ff;
   logic [ROW_W-1:0] row_ff;

   // Ring bookkeeping per side.
   logic [IDX_W-1:0]        left_ptr_ff, left_ptr_in;
   logic [IDX_W-1:0]        right_ptr_ff, right_ptr_in;
   logic [WINDOW_DEPTH-1:0] left_marks_ff, left_marks_in;
   logic [WINDOW_DEPTH-1:0] right_marks_ff, right_marks_in;
   logic [IDX_W-1:0]        ptr_sel;
   logic [IDX_W-1:0]        ptr_next;
   logic [WINDOW_DEPTH-1:0] marks_sel;
   logic                    store;

   // Ring memory.
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [ROW_W-1:0]  rd_data;

   // Accumulators double as dividend and quotient registers.
   logic [SUM_W-1:0] acc_ff [NUM_LANES];
   logic [SUM_W-1:0] acc_in [NUM_LANES];
   logic [CNT_W-1:0] rem_ff [NUM_LANES];
   logic [CNT_W-1:0] rem_in [NUM_LANES];
   logic [CNT_W:0]   shifted [NUM_LANES];
   logic [CNT_W:0]   diff [NUM_LANES];
   logic [NUM_LANES-1:0] fits;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             add_pending_ff;

   // Output register.
   logic               rsp_valid_ff;
   logic [IN_BITS-1:0] avg_ff [NUM_LANES];
   logic               avg_valid_ff;

   // Capture the item; channels are cut to the stored width.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         side_ff <= req_side;
         ok_ff   <= req_sample_ok;
         row_ff  <= {req_clear_in[CHANNEL_BITS-1:0], req_blue_in[CHANNEL_BITS-1:0],
                     req_green_in[CHANNEL_BITS-1:0], req_red_in[CHANNEL_BITS-1:0]};
      end
   end

   // Pointer and marks of the selected side.
   assign ptr_sel   = side_ff ? left_ptr_ff : right_ptr_ff;
   assign marks_sel = side_ff ? left_marks_ff : right_marks_ff;
   assign store     = cmd.write && ok_ff;
   assign ptr_next  = (ptr_sel == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_sel + IDX_W'(1);

   always_comb begin
      left_ptr_in    = left_ptr_ff;
      right_ptr_in   = right_ptr_ff;
      left_marks_in  = left_marks_ff;
      right_marks_in = right_marks_ff;
      if (store) begin
         if (side_ff) begin
            left_ptr_in            = ptr_next;
            left_marks_in[ptr_sel] = 1'b1;
         end else begin
            right_ptr_in            = ptr_next;
            right_marks_in[ptr_sel] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ptr_ff    <= '0;
         right_ptr_ff   <= '0;
         left_marks_ff  <= '0;
         right_marks_ff <= '0;
      end else begin
         left_ptr_ff    <= left_ptr_in;
         right_ptr_ff   <= right_ptr_in;
         left_marks_ff  <= left_marks_in;
         right_marks_ff <= right_marks_in;
      end
   end

   // Both rings share one memory; the side picks the upper address bit.
   assign wr_addr = {side_ff, ptr_sel};
   assign rd_addr = {side_ff, scan_idx};

   drgbc_ma_ram #(
      .WIDTH (ROW_W),
      .DEPTH (RAM_D)
   ) u_ring (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (wr_addr),
      .wr_data (row_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // A read of a marked entry is added when its registered read data arrives.
   always_ff @(posedge clock) begin
      if (reset) begin
         add_pending_ff <= 1'b0;
      end else begin
         add_pending_ff <= cmd.read && marks_sel[scan_idx];
      end
   end

   // Restoring division step, one quotient bit per lane per cycle.
   always_comb begin
      for (int k = 0; k < NUM_LANES; k++) begin
         shifted[k] = {rem_ff[k], acc_ff[k][SUM_W-1]};
         diff[k]    = shifted[k] - {1'b0, count_ff};
         fits[k]    = (shifted[k] >= {1'b0, count_ff});
      end
   end

   // Accumulate, then divide in place.
   always_comb begin
      count_in = count_ff;
      for (int k = 0; k < NUM_LANES; k++) begin
         acc_in[k] = acc_ff[k];
         rem_in[k] = rem_ff[k];
      end
      priority if (cmd.capture) begin
         count_in = '0;
         for (int k = 0; k < NUM_LANES; k++) begin
            acc_in[k] = '0;
            rem_in[k] = '0;
         end
      end else if (add_pending_ff) begin
         count_in = count_ff + CNT_W'(1);
         for (int k = 0; k < NUM_LANES; k++) begin
            acc_in[k] = acc_ff[k] + SUM_W'(rd_data[k*CHANNEL_BITS +: CHANNEL_BITS]);
         end
      end else if (cmd.divide) begin
         for (int k = 0; k < NUM_LANES; k++) begin
            acc_in[k] = {acc_ff[k][SUM_W-2:0], fits[k]};
            rem_in[k] = fits[k] ? diff[k][CNT_W-1:0] : shifted[k][CNT_W-1:0];
         end
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      for (int k = 0; k < NUM_LANES; k++) begin
         acc_ff[k] <= acc_in[k];
         rem_ff[k] <= rem_in[k];
      end
   end

   // Output register; an empty ring gives zeros with the valid flag clear.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         avg_valid_ff <= (count_ff != '0);
         for (int k = 0; k < NUM_LANES; k++) begin
            avg_ff[k] <= (count_ff != '0) ? IN_BITS'(acc_ff[k][CHANNEL_BITS-1:0]) : '0;
         end
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_avg   = avg_ff[LANE_RED];
   assign rsp_green_avg = avg_ff[LANE_GREEN];
   assign rsp_blue_avg  = avg_ff[LANE_BLUE];
   assign rsp_clear_avg = avg_ff[LANE_CLEAR];
   assign rsp_avg_valid = avg_valid_ff;

`ifndef NO_ASSERTIONS
   // The divisor matches the number of marked entries of the selected ring.
   a_count_matches_marks: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (count_ff == CNT_W'($countones(marks_sel))))
      else $error("valid count differs from marked entries");

   // A result is loaded only when the output register can take it.
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwrote a pending item");

   // A stored reading leaves its entry marked.
   a_store_marks: assert property (@(posedge clock) disable iff (reset)
      store |=> marks_sel[$past(ptr_sel)])
      else $error("stored entry not marked");

   // An empty ring yields all-zero averages.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !avg_valid_ff) |->
         (avg_ff[LANE_RED] == '0 && avg_ff[LANE_GREEN] == '0 &&
          avg_ff[LANE_BLUE] == '0 && avg_ff[LANE_CLEAR] == '0))
      else $error("empty ring gave nonzero averages");
`endif

endmodule

// File: rtl/dual_rgbc_valid_moving_average.sv
// Top level of the dual RGBC moving average over valid ring entries.
`timescale 1ns / 1ps

// Each request item is one color reading for the left (side = 1) or right (side = 0)
// sensor. A good reading is stored in that side's WINDOW_DEPTH-entry ring and the
// response item carries each channel averaged over the ring's valid entries, truncated;
// a failed reading only reports the current average, and an empty ring gives zeros with
// avg_valid low. Items are handled one at a time: a request is taken only once the last
// one has passed the scan of the ring through the single read port of its memory, one
// entry a cycle, and the divider, which produces one quotient bit per cycle. A finished
// response waits in an output register, so the next request is taken while it is
// unread. No clearing pass is needed after reset.

module dual_rgbc_valid_moving_average import drgbc_ma_pkg::*; #(
   parameter int WINDOW_DEPTH = 4,
   parameter int CHANNEL_BITS = 16
) (
   input logic              clock,
   input logic              reset,
   drgbc_ma_req_if.sink     req,
   drgbc_ma_rsp_if.source   rsp
);

   localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int SUM_W = CHANNEL_BITS + $clog2(WINDOW_DEPTH);

   cmd_type          cmd;
   status_type       status;
   logic [IDX_W-1:0] scan_idx;

   // Sequencer.
   drgbc_ma_ctrl #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .SUM_W        (SUM_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd),
      .scan_idx  (scan_idx)
   );

   // Datapath.
   drgbc_ma_dp #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .scan_idx      (scan_idx),
      .req_side      (req.side),
      .req_sample_ok (req.sample_ok),
      .req_red_in    (req.red_in),
      .req_green_in  (req.green_in),
      .req_blue_in   (req.blue_in),
      .req_clear_in  (req.clear_in),
      .rsp_valid     (rsp.valid),
      .rsp_ready     (rsp.ready),
      .rsp_red_avg   (rsp.red_avg),
      .rsp_green_avg (rsp.green_avg),
      .rsp_blue_avg  (rsp.blue_avg),
      .rsp_clear_avg (rsp.clear_avg),
      .rsp_avg_valid (rsp.avg_valid)
   );

endmodule
